### rtl/core/b64d_pkg.sv
// Shared types, constants and the character map for the base64 stream decoder.
// Used by every module of the decoder; depends on nothing else.
`default_nettype none

package b64d_pkg;

   // Character codes
   localparam logic [7:0] PAD_CHAR   = 8'h3D;  // '='
   localparam logic [7:0] UPPER_A    = 8'h41;
   localparam logic [7:0] UPPER_Z    = 8'h5A;
   localparam logic [7:0] LOWER_A    = 8'h61;
   localparam logic [7:0] LOWER_Z    = 8'h7A;
   localparam logic [7:0] DIGIT_0    = 8'h30;
   localparam logic [7:0] DIGIT_9    = 8'h39;
   localparam logic [7:0] PLUS_CHAR  = 8'h2B;
   localparam logic [7:0] SLASH_CHAR = 8'h2F;
   localparam logic [5:0] PLUS_VAL   = 6'd62;
   localparam logic [5:0] SLASH_VAL  = 6'd63;
   localparam logic [7:0] LOWER_OFS  = 8'd26;
   localparam logic [7:0] DIGIT_OFS  = 8'd52;

   // Job queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [7:0] sym;
      logic       end_of_string;
   } req_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       last;
   } rsp_type;

   // One job: up to three bytes; nbytes of zero with last set is an empty end marker
   typedef struct packed {
      logic [2:0][7:0] data;
      logic [1:0]      nbytes;
      logic            last;
   } job_type;

   typedef struct packed {
      logic       hit;
      logic [5:0] value;
   } sym_map_type;

   // Alphabet lookup: A-Z, a-z, 0-9, '+', '/'
   function automatic sym_map_type map_sym(input logic [7:0] sym);
      sym_map_type m;
      logic [7:0]  t;
      m = '0;
      t = '0;
      if (sym inside {[UPPER_A:UPPER_Z]}) begin
         t = sym - UPPER_A;
         m.hit = 1'b1;
         m.value = t[5:0];
      end else if (sym inside {[LOWER_A:LOWER_Z]}) begin
         t = sym - LOWER_A + LOWER_OFS;
         m.hit = 1'b1;
         m.value = t[5:0];
      end else if (sym inside {[DIGIT_0:DIGIT_9]}) begin
         t = sym - DIGIT_0 + DIGIT_OFS;
         m.hit = 1'b1;
         m.value = t[5:0];
      end else if (sym == PLUS_CHAR) begin
         m.hit = 1'b1;
         m.value = PLUS_VAL;
      end else if (sym == SLASH_CHAR) begin
         m.hit = 1'b1;
         m.value = SLASH_VAL;
      end
      return m;
   endfunction

endpackage

`default_nettype wire

### rtl/core/base64_stream_decoder_core.sv
// Base64 stream decoder, top level: front end, job queue and result serializer.
// Depends on b64d_pkg, b64d_front, b64d_queue and b64d_back.
//
// Usage:
//   req channel: one character per transaction (sym, end_of_string).
//   rsp channel: one decoded byte per transaction (data_byte, byte_valid, last).
//   A group of four alphabet characters yields three bytes; at end_of_string a
//   partial group yields one or two bytes, and a string with nothing to give
//   yields one result with byte_valid 0. The final result of a string has last.
//   Other characters are skipped; the first '=' stops decoding until the end mark.
// Path: the character that completes a result writes a job into the queue; the
//   back end then loads it into the result register that drives rsp_valid.
// Throughput: one character per cycle in unless req_stall, one result per cycle
//   out unless rsp_stall. The result register moves one byte per cycle, so a
//   string with an end mark on every character runs at one per cycle.
// Stalls: the four-entry job queue absorbs results while rsp_stall is high;
//   req_stall rises only when that queue is full.
// Reset: synchronous; clears the group state, the queue and rsp_valid. No
//   clearing pass is needed; req is accepted the cycle after reset drops.
`default_nettype none

module base64_stream_decoder_core (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire b64d_pkg::req_type req_payload,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output b64d_pkg::rsp_type      rsp_payload
);

   b64d_pkg::job_type job, head;
   logic              job_push, pop, not_empty, q_full;

   b64d_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_payload (req_payload),
      .q_full      (q_full),
      .req_stall   (req_stall),
      .job_push    (job_push),
      .job         (job)
   );

   b64d_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_job  (job),
      .pop       (pop),
      .head      (head),
      .not_empty (not_empty),
      .full      (q_full)
   );

   b64d_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head        (head),
      .not_empty   (not_empty),
      .pop         (pop),
      .rsp_stall   (rsp_stall),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire

### rtl/core/b64d_front.sv
// Front end: accepts characters, classifies them and assembles byte jobs.
// Depends on b64d_pkg.
`default_nettype none

module b64d_front (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire b64d_pkg::req_type req_payload,
   input  wire logic              q_full,
   output logic                   req_stall,
   output logic                   job_push,
   output b64d_pkg::job_type      job
);

   logic [2:0][5:0]       grp_ff, grp_in;
   logic [1:0]            cnt_ff, cnt_in;
   logic                  pad_ff, pad_in;
   logic                  accept;
   logic                  full_grp;
   logic                  is_pad;
   b64d_pkg::sym_map_type map;

   assign req_stall = q_full;
   assign accept    = req_valid && !q_full;

   // Group update and job assembly
   always_comb begin
      map      = b64d_pkg::map_sym(req_payload.sym);
      is_pad   = (req_payload.sym == b64d_pkg::PAD_CHAR);
      grp_in   = grp_ff;
      cnt_in   = cnt_ff;
      pad_in   = pad_ff;
      full_grp = 1'b0;
      if (!pad_ff) begin
         if (is_pad) begin
            pad_in = 1'b1;
         end else if (map.hit) begin
            case (cnt_ff)
               2'd0: begin
                  grp_in[0] = map.value;
                  cnt_in    = 2'd1;
               end
               2'd1: begin
                  grp_in[1] = map.value;
                  cnt_in    = 2'd2;
               end
               2'd2: begin
                  grp_in[2] = map.value;
                  cnt_in    = 2'd3;
               end
               default: begin
                  full_grp = 1'b1;
                  cnt_in   = 2'd0;
               end
            endcase
         end
      end

      // Byte packing; a full group reads the held values plus the new one
      job.data[0] = {grp_in[0], grp_in[1][5:4]};
      job.data[1] = {grp_in[1][3:0], grp_in[2][5:2]};
      job.data[2] = {grp_in[2][1:0], map.value};
      job.last    = req_payload.end_of_string;
      if (full_grp) begin
         job.nbytes = 2'd3;
      end else if (req_payload.end_of_string) begin
         case (cnt_in)
            2'd3:    job.nbytes = 2'd2;
            2'd2:    job.nbytes = 2'd1;
            default: job.nbytes = 2'd0;
         endcase
      end else begin
         job.nbytes = 2'd0;
      end
      job_push = accept && (full_grp || req_payload.end_of_string);

      // End mark returns the group to empty
      if (req_payload.end_of_string) begin
         cnt_in = 2'd0;
         pad_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
         pad_ff <= 1'b0;
      end else if (accept) begin
         cnt_ff <= cnt_in;
         pad_ff <= pad_in;
      end
      if (accept) begin
         grp_ff <= grp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/b64d_queue.sv
// Short job queue that decouples the front end from the result serializer.
// Depends on b64d_pkg.
`default_nettype none

module b64d_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire b64d_pkg::job_type push_job,
   input  wire logic              pop,
   output b64d_pkg::job_type      head,
   output logic                   not_empty,
   output logic                   full
);

   b64d_pkg::job_type               q_mem [b64d_pkg::QUEUE_DEPTH];
   logic [b64d_pkg::QUEUE_AW-1:0]   wptr_ff, rptr_ff;
   logic [b64d_pkg::QUEUE_AW:0]     count_ff, count_in;

   assign head      = q_mem[rptr_ff];
   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == (b64d_pkg::QUEUE_AW+1)'(b64d_pkg::QUEUE_DEPTH));

   // Occupancy
   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         if (push) wptr_ff <= wptr_ff + 1'b1;
         if (pop)  rptr_ff <= rptr_ff + 1'b1;
         count_ff <= count_in;
      end
      if (push) begin
         q_mem[wptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

### rtl/core/b64d_back.sv
// Back end: walks each queued job and presents one result per transaction.
// Depends on b64d_pkg.
`default_nettype none

module b64d_back (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire b64d_pkg::job_type head,
   input  wire logic              not_empty,
   output logic                   pop,
   input  wire logic              rsp_stall,
   output logic                   rsp_valid,
   output b64d_pkg::rsp_type      rsp_payload
);

   logic [1:0]        idx_ff, idx_in;
   logic              rsp_valid_ff;
   b64d_pkg::rsp_type rsp_ff, rsp_in;
   logic              load;
   logic              final_res;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   // Next result from the head job
   always_comb begin
      load      = not_empty && (!rsp_valid_ff || !rsp_stall);
      final_res = (head.nbytes == 2'd0) || ((idx_ff + 2'd1) == head.nbytes);
      pop       = load && final_res;
      idx_in    = final_res ? 2'd0 : idx_ff + 2'd1;
      rsp_in.byte_valid = (head.nbytes != 2'd0);
      rsp_in.data_byte  = rsp_in.byte_valid ? head.data[idx_ff] : 8'd0;
      rsp_in.last       = head.last && final_res;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 2'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            idx_ff       <= idx_in;
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/b64d_checker.sv
// Port-level checks for the base64 stream decoder, bound to the top level.
// Depends on b64d_pkg and base64_stream_decoder_core.
`default_nettype none

module b64d_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire b64d_pkg::rsp_type rsp_payload
);

   // No result is pending right after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("rsp_valid high after reset");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("stalled result changed");

   // An empty result only closes a string and carries a zero byte
   a_empty_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.byte_valid |->
         rsp_payload.last && (rsp_payload.data_byte == 8'd0))
      else $error("empty result without last");

   // Input backpressure only while results are backed up
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("req_stall with no pending result");

   // rsp_valid is known after every accepted character
   a_req_known: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> !$isunknown(rsp_valid))
      else $error("rsp_valid unknown after accept");

endmodule

bind base64_stream_decoder_core b64d_checker u_b64d_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

`default_nettype wire
